// ===== hw/rtl/rwl_pkg.sv =====
// Shared types and constants of the reader/writer lock table.
// Used by every module of the block but rwl_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rwl_pkg;

    localparam int LOCK_SLOTS = 16;
    localparam int WAIT_DEPTH = 32;
    localparam int QDEPTH     = 2;

    localparam int SLOT_W = $clog2(LOCK_SLOTS);
    localparam int LEN_W  = $clog2(WAIT_DEPTH + 1);
    localparam int IDX_W  = LEN_W;
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int RAM_DEPTH = LOCK_SLOTS << IDX_W;
    localparam int CNT_W  = 8;
    localparam int KEY_W  = 32;
    localparam int ID_W   = 8;
    localparam int KIND_W = 3;
    localparam int ST_W   = 2;

    localparam logic [KIND_W-1:0] K_CREATE  = 3'd0;
    localparam logic [KIND_W-1:0] K_RLOCK   = 3'd1;
    localparam logic [KIND_W-1:0] K_WLOCK   = 3'd2;
    localparam logic [KIND_W-1:0] K_RUNLOCK = 3'd3;
    localparam logic [KIND_W-1:0] K_WUNLOCK = 3'd4;
    localparam logic [KIND_W-1:0] K_DELETE  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ERR  = 2'd1;
    localparam logic [ST_W-1:0] ST_WAIT = 2'd2;

    typedef struct packed {
        logic              legal;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   who;
    } t_req;

endpackage
`default_nettype wire

// ===== hw/rtl/reader_writer_lock_manager.sv =====
// Top level of the reader/writer lock table: front end, request queue, back end.
// Depends on rwl_pkg, rwl_front, rwl_back (and rwl_ram through rwl_back).
`timescale 1ns / 1ps
`default_nettype none
// A request passes from the queue head to its reply through pop, key
// match against all lock slots, state update with reply and the output
// register; every grant it releases is read from the wait-queue memory
// one entry per cycle while the output register can take it. Up to two
// requests wait in the queue between the front and back ends, so the
// input side keeps accepting while a reply stalls until that queue is full.
// Writer queues are rings per slot; reader queues drain all at once.
// The waiting-client memories need no clearing after reset.
module reader_writer_lock_manager import rwl_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [39:0]         s_axis_tdata,  // resource_key[31:0], requester[39:32]
    input  wire logic [KIND_W-1:0]   s_axis_tuser,  // kind[2:0]
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [7:0]               m_axis_tdata,  // target[7:0]
    output logic [ST_W-1:0]          m_axis_tuser,  // status[1:0]
    output logic                     m_axis_tlast
);
    logic w_q_valid, w_q_pop;
    t_req w_q_req;

    // accept and classify; hold in the queue
    rwl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_key(s_axis_tdata[31:0]), .i_who(s_axis_tdata[39:32]),
        .o_q_valid(w_q_valid), .o_q_req(w_q_req), .i_q_pop(w_q_pop));

    // advance the lock state and emit the replies
    rwl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .i_q_req(w_q_req), .o_q_pop(w_q_pop),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_target(m_axis_tdata), .o_status(m_axis_tuser), .o_last(m_axis_tlast));

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid) else $error("queue popped while empty");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_ERR ||
                           m_axis_tuser == ST_WAIT)) else $error("bad status code");

    a_wait_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tlast)
        else $error("error or wait reply not final");

    // first edge out of reset: the output register was just cleared
    a_quiet_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_axis_tvalid) else $error("reply right after reset");
endmodule
`default_nettype wire

// ===== hw/rtl/rwl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rwl_front.sv =====
// Front end: accept request items, classify the kind, hold them in a short queue.
// Depends on rwl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rwl_front import rwl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [ID_W-1:0]   i_who,
    output logic                   o_q_valid,
    output t_req                   o_q_req,
    input  wire logic              i_q_pop
);
    localparam int PTR_W = $clog2(QDEPTH);

    t_req               r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_cnt;
    t_req               w_req;
    logic               w_push, w_pop;

    always_comb begin
        w_req.legal = (i_kind <= K_DELETE);
        w_req.kind  = i_kind;
        w_req.key   = i_key;
        w_req.who   = i_who;
    end

    assign o_ready   = (r_cnt != (PTR_W+1)'(QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_req;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rwl_back.sv =====
// Back end: key match, lock state update, wait queues and reply sequencing.
// Depends on rwl_pkg and rwl_ram.
`timescale 1ns / 1ps
`default_nettype none
module rwl_back import rwl_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire t_req            i_q_req,
    output logic                 o_q_pop,
    output logic                 o_tvalid,
    input  wire logic            i_tready,
    output logic [ID_W-1:0]      o_target,
    output logic [ST_W-1:0]      o_status,
    output logic                 o_last
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_GW    = 3'd3;
    localparam logic [2:0] S_GR    = 3'd4;

    logic [2:0]        r_state, n_state;
    t_req              r_req, n_req;
    logic              r_hit, n_hit, r_free, n_free;
    logic [SLOT_W-1:0] r_slot, n_slot, r_fslot, n_fslot;
    logic [IDX_W-1:0]  r_gi, n_gi;

    logic              r_valid [LOCK_SLOTS], n_valid [LOCK_SLOTS];
    logic [KEY_W-1:0]  r_key   [LOCK_SLOTS], n_key   [LOCK_SLOTS];
    logic [CNT_W-1:0]  r_rcnt  [LOCK_SLOTS], n_rcnt  [LOCK_SLOTS];
    logic              r_wheld [LOCK_SLOTS], n_wheld [LOCK_SLOTS];
    logic [LEN_W-1:0]  r_rlen  [LOCK_SLOTS], n_rlen  [LOCK_SLOTS];
    logic [LEN_W-1:0]  r_wlen  [LOCK_SLOTS], n_wlen  [LOCK_SLOTS];
    logic [IDX_W-1:0]  r_whead [LOCK_SLOTS], n_whead [LOCK_SLOTS];

    logic              r_ov, n_ov, r_olast, n_olast;
    logic [ID_W-1:0]   r_otgt, n_otgt;
    logic [ST_W-1:0]   r_ost, n_ost;

    logic              w_rwe, w_rre, w_wwe, w_wre;
    logic [ADDR_W-1:0] w_rwa, w_rra, w_wwa, w_wra;
    logic [ID_W-1:0]   w_rdata, w_wdata;
    logic              w_out_free;

    rwl_ram #(.WIDTH(ID_W), .DEPTH(RAM_DEPTH)) u_rd_ram (
        .i_clk(i_clk), .i_we(w_rwe), .i_waddr(w_rwa), .i_wdata(r_req.who),
        .i_re(w_rre), .i_raddr(w_rra), .o_rdata(w_rdata));

    rwl_ram #(.WIDTH(ID_W), .DEPTH(RAM_DEPTH)) u_wr_ram (
        .i_clk(i_clk), .i_we(w_wwe), .i_waddr(w_wwa), .i_wdata(r_req.who),
        .i_re(w_wre), .i_raddr(w_wra), .o_rdata(w_wdata));

    assign w_out_free = !r_ov || i_tready;
    assign o_tvalid   = r_ov;
    assign o_target   = r_otgt;
    assign o_status   = r_ost;
    assign o_last     = r_olast;

    always_comb begin
        logic [SLOT_W-1:0] s;
        logic              emit;
        s        = r_slot;
        emit     = 1'b0;
        n_state  = r_state;
        n_req    = r_req;
        n_hit    = r_hit;
        n_free   = r_free;
        n_slot   = r_slot;
        n_fslot  = r_fslot;
        n_gi     = r_gi;
        n_valid  = r_valid;
        n_key    = r_key;
        n_rcnt   = r_rcnt;
        n_wheld  = r_wheld;
        n_rlen   = r_rlen;
        n_wlen   = r_wlen;
        n_whead  = r_whead;
        n_otgt   = r_otgt;
        n_ost    = r_ost;
        n_olast  = r_olast;
        o_q_pop  = 1'b0;
        w_rwe    = 1'b0;
        w_rre    = 1'b0;
        w_wwe    = 1'b0;
        w_wre    = 1'b0;
        w_rwa    = {s, r_rlen[s]};
        w_rra    = {s, IDX_W'(0)};
        w_wwa    = {s, IDX_W'(r_whead[s] + r_wlen[s])};
        w_wra    = {s, r_whead[s]};

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_req   = i_q_req;
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_hit  = 1'b0;
                n_free = 1'b0;
                for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
                    if (r_valid[i] && r_key[i] == r_req.key) begin
                        n_hit  = 1'b1;
                        n_slot = SLOT_W'(i);
                    end
                    if (!r_valid[i]) begin
                        n_free  = 1'b1;
                        n_fslot = SLOT_W'(i);
                    end
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    emit    = 1'b1;
                    n_otgt  = r_req.who;
                    n_ost   = ST_ERR;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                    if (r_req.legal) begin
                        case (r_req.kind)
                            K_CREATE: begin
                                if (!r_hit && r_free) begin
                                    n_valid[r_fslot] = 1'b1;
                                    n_key[r_fslot]   = r_req.key;
                                    n_rcnt[r_fslot]  = '0;
                                    n_wheld[r_fslot] = 1'b0;
                                    n_rlen[r_fslot]  = '0;
                                    n_wlen[r_fslot]  = '0;
                                    n_ost            = ST_OK;
                                end
                            end
                            K_RLOCK: begin
                                if (r_hit && r_wheld[s]) begin
                                    if (r_rlen[s] < LEN_W'(WAIT_DEPTH)) begin
                                        w_rwe     = 1'b1;
                                        n_rlen[s] = r_rlen[s] + 1'b1;
                                        n_ost     = ST_WAIT;
                                    end
                                end else if (r_hit && r_rcnt[s] != '1) begin
                                    n_rcnt[s] = r_rcnt[s] + 1'b1;
                                    n_ost     = ST_OK;
                                end
                            end
                            K_WLOCK: begin
                                if (r_hit && (r_wheld[s] || r_rcnt[s] != '0)) begin
                                    if (r_wlen[s] < LEN_W'(WAIT_DEPTH)) begin
                                        w_wwe     = 1'b1;
                                        n_wlen[s] = r_wlen[s] + 1'b1;
                                        n_ost     = ST_WAIT;
                                    end
                                end else if (r_hit) begin
                                    n_wheld[s] = 1'b1;
                                    n_ost      = ST_OK;
                                end
                            end
                            K_RUNLOCK: begin
                                if (r_hit && r_rcnt[s] != '0 && !r_wheld[s]) begin
                                    n_ost     = ST_OK;
                                    n_rcnt[s] = r_rcnt[s] - 1'b1;
                                    if (r_rcnt[s] == CNT_W'(1) && r_wlen[s] != '0) begin
                                        w_wre   = 1'b1;
                                        n_olast = 1'b0;
                                        n_state = S_GW;
                                    end
                                end
                            end
                            K_WUNLOCK: begin
                                if (r_hit && r_wheld[s] && r_rcnt[s] == '0) begin
                                    n_ost      = ST_OK;
                                    n_wheld[s] = 1'b0;
                                    if (r_wlen[s] != '0) begin
                                        w_wre   = 1'b1;
                                        n_olast = 1'b0;
                                        n_state = S_GW;
                                    end else if (r_rlen[s] != '0) begin
                                        w_rre   = 1'b1;
                                        n_gi    = '0;
                                        n_olast = 1'b0;
                                        n_state = S_GR;
                                    end
                                end
                            end
                            K_DELETE: begin
                                if (r_hit) begin
                                    n_valid[s] = 1'b0;
                                    n_rcnt[s]  = '0;
                                    n_wheld[s] = 1'b0;
                                    n_rlen[s]  = '0;
                                    n_wlen[s]  = '0;
                                    n_ost      = ST_OK;
                                end
                            end
                            default: n_ost = ST_ERR;
                        endcase
                    end
                end
            end
            S_GW: begin
                // grant the oldest queued writer
                if (w_out_free) begin
                    emit       = 1'b1;
                    n_otgt     = w_wdata;
                    n_ost      = ST_OK;
                    n_olast    = 1'b1;
                    n_wheld[s] = 1'b1;
                    n_whead[s] = r_whead[s] + 1'b1;
                    n_wlen[s]  = r_wlen[s] - 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_GR: begin
                // walk the reader queue, one grant per cycle while the output register is free
                if (w_out_free) begin
                    emit    = 1'b1;
                    n_otgt  = w_rdata;
                    n_ost   = ST_OK;
                    n_olast = (LEN_W'(r_gi) == r_rlen[s] - 1'b1);
                    if (r_rcnt[s] != '1) begin
                        n_rcnt[s] = r_rcnt[s] + 1'b1;
                    end
                    if (n_olast) begin
                        n_rlen[s] = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_gi  = r_gi + 1'b1;
                        w_rre = 1'b1;
                        w_rra = {s, n_gi};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_ov = 1'b1;
        end else if (i_tready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_hit   <= n_hit;
        r_free  <= n_free;
        r_slot  <= n_slot;
        r_fslot <= n_fslot;
        r_gi    <= n_gi;
        r_key   <= n_key;
        r_otgt  <= n_otgt;
        r_ost   <= n_ost;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < LOCK_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_rcnt[i]  <= '0;
                r_wheld[i] <= 1'b0;
                r_rlen[i]  <= '0;
                r_wlen[i]  <= '0;
                r_whead[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_valid <= n_valid;
            r_rcnt  <= n_rcnt;
            r_wheld <= n_wheld;
            r_rlen  <= n_rlen;
            r_wlen  <= n_wlen;
            r_whead <= n_whead;
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_reader_writer_lock_manager.sv =====
// Self-checking testbench of the reader/writer lock table (reader_writer_lock_manager).
// Depends on rwl_pkg and the RTL; drives request items and checks every reply item
// against its own lock-table predictor.
`timescale 1ns / 1ps
module tb_reader_writer_lock_manager;
    import rwl_pkg::*;

    // Kind codes the block does not define; both must give a single error.
    localparam logic [KIND_W-1:0] K_UNDEF_LO = 3'd6;
    localparam logic [KIND_W-1:0] K_UNDEF_HI = 3'd7;
    localparam int RANDOM_ITEMS = 64;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [ID_W-1:0] target;
        logic [ST_W-1:0] status;
        logic            last;
    } t_reply;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   who;
        bit                typed;   // expected reply typed in below
        logic [ST_W-1:0]   status;
    } t_req_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata = '0;   // resource_key[31:0], requester[39:32]
    logic [KIND_W-1:0]   s_axis_tuser = '0;   // kind[2:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;        // target[7:0]
    logic [ST_W-1:0]     m_axis_tuser;        // status[1:0]
    logic                m_axis_tlast;

    // Predictor copy of the lock table.
    bit                  lk_used    [LOCK_SLOTS];
    logic [KEY_W-1:0]    lk_key     [LOCK_SLOTS];
    int unsigned         lk_readers [LOCK_SLOTS];
    bit                  lk_writer  [LOCK_SLOTS];
    logic [ID_W-1:0]     rd_waiting [LOCK_SLOTS][$];
    logic [ID_W-1:0]     wr_waiting [LOCK_SLOTS][$];

    t_reply              replies_due[$];
    int                  mismatches = 0;
    bit                  calm = 1'b0;         // no idling on either side while set

    reader_writer_lock_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("tb_reader_writer_lock_manager: FAIL");
        $finish;
    end

    function automatic int lookup_slot(input logic [KEY_W-1:0] key);
        for (int s = 0; s < LOCK_SLOTS; s++)
            if (lk_used[s] && lk_key[s] == key)
                return s;
        return -1;
    endfunction

    // Work out the replies one accepted request causes, and update the table.
    function automatic void predict_replies(input logic [KIND_W-1:0] kind,
                                            input logic [KEY_W-1:0] key,
                                            input logic [ID_W-1:0] who);
        t_reply outs[$];
        int     s;
        int     f;
        s = lookup_slot(key);
        case (kind)
            K_CREATE: begin
                f = -1;
                for (int i = LOCK_SLOTS - 1; i >= 0; i--)
                    if (!lk_used[i])
                        f = i;
                if (s >= 0 || f < 0) begin
                    outs.push_back('{who, ST_ERR, 1'b0});
                end else begin
                    lk_used[f] = 1'b1;
                    lk_key[f] = key;
                    lk_readers[f] = 0;
                    lk_writer[f] = 1'b0;
                    rd_waiting[f].delete();
                    wr_waiting[f].delete();
                    outs.push_back('{who, ST_OK, 1'b0});
                end
            end
            K_RLOCK: begin
                if (s < 0) begin
                    outs.push_back('{who, ST_ERR, 1'b0});
                end else if (lk_writer[s]) begin
                    if (rd_waiting[s].size() >= WAIT_DEPTH) begin
                        outs.push_back('{who, ST_ERR, 1'b0});
                    end else begin
                        rd_waiting[s].push_back(who);
                        outs.push_back('{who, ST_WAIT, 1'b0});
                    end
                end else if (lk_readers[s] == 255) begin
                    outs.push_back('{who, ST_ERR, 1'b0});
                end else begin
                    lk_readers[s]++;
                    outs.push_back('{who, ST_OK, 1'b0});
                end
            end
            K_WLOCK: begin
                if (s < 0) begin
                    outs.push_back('{who, ST_ERR, 1'b0});
                end else if (lk_writer[s] || lk_readers[s] != 0) begin
                    if (wr_waiting[s].size() >= WAIT_DEPTH) begin
                        outs.push_back('{who, ST_ERR, 1'b0});
                    end else begin
                        wr_waiting[s].push_back(who);
                        outs.push_back('{who, ST_WAIT, 1'b0});
                    end
                end else begin
                    lk_writer[s] = 1'b1;
                    outs.push_back('{who, ST_OK, 1'b0});
                end
            end
            K_RUNLOCK: begin
                if (s < 0 || lk_readers[s] == 0 || lk_writer[s]) begin
                    outs.push_back('{who, ST_ERR, 1'b0});
                end else begin
                    outs.push_back('{who, ST_OK, 1'b0});
                    lk_readers[s]--;
                    // last reader out hands the lock to the oldest writer
                    if (lk_readers[s] == 0 && wr_waiting[s].size() != 0) begin
                        lk_writer[s] = 1'b1;
                        outs.push_back('{wr_waiting[s].pop_front(), ST_OK, 1'b0});
                    end
                end
            end
            K_WUNLOCK: begin
                if (s < 0 || !lk_writer[s] || lk_readers[s] != 0) begin
                    outs.push_back('{who, ST_ERR, 1'b0});
                end else begin
                    outs.push_back('{who, ST_OK, 1'b0});
                    if (wr_waiting[s].size() != 0) begin
                        outs.push_back('{wr_waiting[s].pop_front(), ST_OK, 1'b0});
                    end else begin
                        lk_writer[s] = 1'b0;
                        // release every queued reader at once, oldest first
                        while (rd_waiting[s].size() != 0) begin
                            outs.push_back('{rd_waiting[s].pop_front(), ST_OK, 1'b0});
                            if (lk_readers[s] != 255)
                                lk_readers[s]++;
                        end
                    end
                end
            end
            K_DELETE: begin
                if (s < 0) begin
                    outs.push_back('{who, ST_ERR, 1'b0});
                end else begin
                    lk_used[s] = 1'b0;
                    lk_readers[s] = 0;
                    lk_writer[s] = 1'b0;
                    rd_waiting[s].delete();
                    wr_waiting[s].delete();
                    outs.push_back('{who, ST_OK, 1'b0});
                end
            end
            default: outs.push_back('{who, ST_ERR, 1'b0});
        endcase
        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            replies_due.push_back(outs[i]);
    endfunction

    // Offer one request item and hold it until the block takes it. Ready is
    // sampled at the falling edge, where it is stable up to the next rising edge.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                                input logic [ID_W-1:0] who, input bit typed = 1'b0,
                                input logic [ST_W-1:0] status = ST_OK);
        bit taken;
        if (!calm && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < 50);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {who, key};
        s_axis_tuser  <= kind;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        if (typed) begin
            // still advance the predictor, but hold the block to the typed reply
            predict_replies(kind, key, who);
            void'(replies_due.pop_back());
            replies_due.push_back('{who, status, 1'b1});
        end else begin
            predict_replies(kind, key, who);
        end
    endtask

    // Receiver side: stall at random, and check each reply item taken.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 16);
            if (m_axis_tvalid && m_axis_tready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected reply: target %0h status %0d last %0b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = replies_due.pop_front();
                    if (m_axis_tdata !== want.target || m_axis_tuser !== want.status
                            || m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("reply mismatch: expected %0h/%0d/%0b, got %0h/%0d/%0b",
                                     want.target, want.status, want.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
        end
    end

    t_req_row directed[] = '{
        '{K_CREATE,   32'h0000_0000, 8'h01, 1'b1, ST_OK},
        '{K_CREATE,   32'h0000_0000, 8'h02, 1'b1, ST_ERR},   // key already present
        '{K_CREATE,   32'hFFFF_FFFF, 8'h03, 1'b1, ST_OK},
        '{K_RLOCK,    32'h1234_5678, 8'h04, 1'b1, ST_ERR},   // unknown key
        '{K_UNDEF_LO, 32'h0000_0000, 8'h05, 1'b1, ST_ERR},
        '{K_UNDEF_HI, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_ERR},
        '{K_WLOCK,    32'h0000_0000, 8'hFF, 1'b1, ST_OK},
        '{K_RLOCK,    32'h0000_0000, 8'h10, 1'b1, ST_WAIT},  // writer holds
        '{K_RLOCK,    32'h0000_0000, 8'h11, 1'b1, ST_WAIT},
        '{K_WLOCK,    32'h0000_0000, 8'h20, 1'b1, ST_WAIT},
        '{K_RUNLOCK,  32'h0000_0000, 8'h30, 1'b1, ST_ERR},   // writer holds
        '{K_WUNLOCK,  32'h0000_0000, 8'h31, 1'b0, ST_OK},    // hands over to writer 20
        '{K_WUNLOCK,  32'h0000_0000, 8'h32, 1'b0, ST_OK},    // releases both readers
        '{K_WLOCK,    32'h0000_0000, 8'h21, 1'b0, ST_OK},
        '{K_RUNLOCK,  32'h0000_0000, 8'h33, 1'b0, ST_OK},
        '{K_RUNLOCK,  32'h0000_0000, 8'h34, 1'b0, ST_OK},    // last reader, grants 21
        '{K_WUNLOCK,  32'hFFFF_FFFF, 8'h35, 1'b1, ST_ERR},   // no writer
        '{K_RUNLOCK,  32'hFFFF_FFFF, 8'h36, 1'b1, ST_ERR},   // no readers
        '{K_DELETE,   32'h0000_0000, 8'h37, 1'b1, ST_OK},
        '{K_DELETE,   32'h0000_0000, 8'h38, 1'b1, ST_ERR},
        '{K_WUNLOCK,  32'h0000_0000, 8'h39, 1'b1, ST_ERR}
    };

    initial begin
        logic [KEY_W-1:0]  key_pool [6];
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        int                pick;
        int                cycles;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_request(directed[i].kind, directed[i].key, directed[i].who,
                         directed[i].typed, directed[i].status);

        // Saturate the reader count: the 256th read lock is refused.
        for (int i = 0; i < 256; i++)
            send_request(K_RLOCK, 32'hFFFF_FFFF, 8'(i));
        send_request(K_DELETE, 32'hFFFF_FFFF, 8'h40);

        // Fill both wait queues past their depth, then drain them.
        send_request(K_CREATE, 32'hA5A5_5A5A, 8'h41);
        send_request(K_WLOCK,  32'hA5A5_5A5A, 8'h42);
        for (int i = 0; i <= WAIT_DEPTH; i++)
            send_request(K_RLOCK, 32'hA5A5_5A5A, 8'($urandom_range(255)));
        for (int i = 0; i <= WAIT_DEPTH; i++)
            send_request(K_WLOCK, 32'hA5A5_5A5A, 8'($urandom_range(255)));
        // each write unlock passes to the next writer; the last frees all readers
        for (int i = 0; i <= WAIT_DEPTH; i++)
            send_request(K_WUNLOCK, 32'hA5A5_5A5A, 8'($urandom_range(255)));
        send_request(K_DELETE, 32'hA5A5_5A5A, 8'h43);

        // Fill the table; the create beyond it is refused.
        for (int i = 0; i <= LOCK_SLOTS; i++)
            send_request(K_CREATE, 32'h0100_0000 + i, 8'(i));
        for (int i = 0; i <= LOCK_SLOTS; i++)
            send_request(K_DELETE, 32'h0100_0000 + i, 8'(i));

        // Random traffic, mostly on a few keys so that locks contend.
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            key_pool[i] = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 24 && n < 48);
            pick = $urandom_range(99);
            if (pick < 12)      kind = K_CREATE;
            else if (pick < 37) kind = K_RLOCK;
            else if (pick < 57) kind = K_WLOCK;
            else if (pick < 75) kind = K_RUNLOCK;
            else if (pick < 93) kind = K_WUNLOCK;
            else if (pick < 97) kind = K_DELETE;
            else                kind = 3'($urandom_range(7));
            key = ($urandom_range(9) == 0) ? 32'($urandom) : key_pool[$urandom_range(5)];
            send_request(kind, key, 8'($urandom_range(255)));
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge i_clk);
        // let any stray reply show up
        for (cycles = 0; cycles < DRAIN_CYCLES; cycles++)
            @(posedge i_clk);

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("tb_reader_writer_lock_manager: PASS");
        end else begin
            $display("tb_reader_writer_lock_manager: FAIL");
        end
        $finish;
    end

endmodule
